@@ hw/rtl/tcw_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared codes and types of the text console character writer: command codes,
// control bytes and the control/status bundles between sequencer and cursor.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// command codes
	localparam logic [1:0] CMD_PUT   = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// control and blank bytes
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// attribute after reset
	localparam logic [7:0] ATTR_RESET = 8'h0F;

	// sequencer to cursor unit
	typedef struct packed {
		logic       put;    // put-character transfer taken this cycle
		logic       home;   // clear command taken this cycle
		logic [7:0] code;   // character byte
	} cur_ctl_t;

	// cursor unit to sequencer
	typedef struct packed {
		logic printable;    // byte goes into the store at the current cursor
		logic scroll;       // cursor ran past the last row
	} cur_sts_t;

endpackage
`default_nettype wire

@@ hw/rtl/text_console_character_writer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_character_writer
// Text console engine: a COLUMNS x ROWS store of 16-bit cells (attribute in
// the high byte, character in the low byte) and a cursor. Put-character,
// clear-screen and read-cell commands; one result per command.
//
//   channel  signals                                 transfer when
//   -------  --------------------------------------  -----------------------
//   config   cfg_valid cfg_ready cfg_data[7:0]       cfg_valid & cfg_ready
//   command  start busy cmd char_code cell_index     start & !busy
//   result   done cursor_position read_data          done (one cycle, no stall)
//
// A put-character without scroll leaves the engine idle: its result follows
// in the next cycle and the next command is taken at once. A read passes
// through ST_READ (registered store read). Scroll walks the store through its
// one read port and one write port, then blanks the last row in ST_FILL; clear
// fills the whole store. After reset a clearing pass (ST_INIT) runs with busy
// high; cfg_ready is always high. The result side cannot stall.
// ----------------------------------------------------------------------------
module text_console_character_writer #(
	parameter int COLUMNS  = 80,
	parameter int ROWS     = 25,
	parameter int TAB_STEP = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	// configuration
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [7:0]  cfg_data,
	// command
	input  wire         start,
	output logic        busy,
	input  wire  [1:0]  cmd,
	input  wire  [7:0]  char_code,
	input  wire  [10:0] cell_index,
	// result
	output logic        done,
	output logic [10:0] cursor_position,
	output logic [15:0] read_data
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int PW    = $clog2(CELLS + 1);
	localparam int IXW   = (PW > 11) ? PW : 11;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_INIT   = 5'b00010,
		ST_READ   = 5'b00100,
		ST_SCROLL = 5'b01000,
		ST_FILL   = 5'b10000
	} state_t;

	state_t             state_q;
	logic [PW-1:0]      ptr_q;      // sweep pointer
	logic               wv_q;       // copy write pending
	logic [AW-1:0]      wa_q;       // copy write address
	logic               rng_q;      // read index inside the store
	logic [7:0]         attr_q;
	logic               done_q;
	logic [15:0]        read_data_q;
	logic [15:0]        rd_q;       // registered store read data
	logic [15:0]        mem [CELLS];

	logic               accept;
	tcw_pkg::cur_ctl_t  ctl;
	tcw_pkg::cur_sts_t  sts;
	logic [AW-1:0]      cur_lin;

	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	logic [15:0]        mem_wd;
	logic               mem_re;
	logic [AW-1:0]      mem_ra;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start & ~busy;
	assign cfg_ready = 1'b1;

	// cursor unit control
	assign ctl.put  = accept & (cmd == tcw_pkg::CMD_PUT);
	assign ctl.home = accept & (cmd == tcw_pkg::CMD_CLEAR);
	assign ctl.code = char_code;

	tcw_cursor #(
		.COLUMNS  (COLUMNS),
		.ROWS     (ROWS),
		.TAB_STEP (TAB_STEP)
	) u_cursor (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.sts     (sts),
		.cur_lin (cur_lin)
	);

	// store port selection
	always_comb begin
		mem_we = 1'b0;
		mem_wa = ptr_q[AW-1:0];
		mem_wd = {attr_q, tcw_pkg::CH_SPACE};
		mem_re = 1'b0;
		mem_ra = ptr_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				mem_we = sts.printable;
				mem_wa = cur_lin;
				mem_wd = {attr_q, char_code};
				mem_re = accept & (cmd == tcw_pkg::CMD_READ);
				mem_ra = AW'(cell_index);
			end
			ST_INIT: begin
				mem_we = 1'b1;
				mem_wd = {tcw_pkg::ATTR_RESET, tcw_pkg::CH_SPACE};
			end
			ST_SCROLL: begin
				mem_re = (ptr_q < PW'(CELLS));
				mem_we = wv_q;
				mem_wa = wa_q;
				mem_wd = rd_q;
			end
			ST_FILL: begin
				mem_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// cell store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem[mem_ra];
		end
	end

	// attribute register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tcw_pkg::ATTR_RESET;
		end else if (cfg_valid & cfg_ready) begin
			attr_q <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			ptr_q   <= '0;
			wv_q    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd)
							tcw_pkg::CMD_PUT: begin
								if (sts.scroll) begin
									state_q <= ST_SCROLL;
									ptr_q   <= PW'(COLUMNS);
									wv_q    <= 1'b0;
								end else begin
									done_q <= 1'b1;
								end
							end
							tcw_pkg::CMD_CLEAR: begin
								state_q <= ST_FILL;
								ptr_q   <= '0;
							end
							tcw_pkg::CMD_READ: begin
								state_q <= ST_READ;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_INIT: begin
					if (ptr_q == PW'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + PW'(1);
					end
				end
				ST_READ: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_SCROLL: begin
					// read one row down, write it one row up in the next cycle
					wv_q <= (ptr_q < PW'(CELLS));
					if (ptr_q == PW'(CELLS)) begin
						state_q <= ST_FILL;
						ptr_q   <= PW'((ROWS - 1) * COLUMNS);
					end else begin
						ptr_q <= ptr_q + PW'(1);
					end
				end
				ST_FILL: begin
					if (ptr_q == PW'(CELLS - 1)) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + PW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_SCROLL) begin
			wa_q <= AW'(ptr_q - PW'(COLUMNS));
		end
		if (accept) begin
			rng_q <= (IXW'(cell_index) < IXW'(CELLS));
		end
		if (state_q == ST_READ) begin
			read_data_q <= rng_q ? rd_q : 16'h0000;
		end else begin
			read_data_q <= 16'h0000;
		end
	end

	assign done            = done_q;
	assign read_data       = read_data_q;
	assign cursor_position = 11'(cur_lin);

endmodule
`default_nettype wire

@@ hw/rtl/tcw_cursor.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_cursor
// Cursor column/row registers and the put-character cursor update: backspace,
// tab, carriage return, line feed, advance, column wrap and scroll detection.
// ----------------------------------------------------------------------------
module tcw_cursor #(
	parameter int COLUMNS  = 80,
	parameter int ROWS     = 25,
	parameter int TAB_STEP = 8,
	localparam int LW      = $clog2(COLUMNS * ROWS)
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire tcw_pkg::cur_ctl_t ctl,
	output tcw_pkg::cur_sts_t      sts,
	output logic [LW-1:0]          cur_lin
);

	localparam int CW  = $clog2(COLUMNS);
	localparam int CNW = $clog2(COLUMNS + TAB_STEP);
	localparam int RW  = $clog2(ROWS);
	localparam int RNW = $clog2(ROWS + 1);
	localparam int TPW = $clog2(TAB_STEP);

	logic [CW-1:0]  col_q;
	logic [RW-1:0]  row_q;
	logic [TPW-1:0] tph_q;      // col_q modulo TAB_STEP, kept alongside

	logic [CNW-1:0] ncol;
	logic [TPW-1:0] nph;
	logic           rowinc;
	logic [RNW-1:0] nrow;
	logic           printable;
	logic           scroll;

	// next cursor for the byte at hand
	always_comb begin
		ncol      = CNW'(col_q);
		nph       = tph_q;
		rowinc    = 1'b0;
		printable = 1'b0;
		case (ctl.code)
			tcw_pkg::CH_BS: begin
				if (col_q != '0) begin
					ncol = CNW'(col_q) - CNW'(1);
					nph  = (tph_q == '0) ? TPW'(TAB_STEP - 1) : tph_q - TPW'(1);
				end
			end
			tcw_pkg::CH_TAB: begin
				ncol = CNW'(col_q) + CNW'(TAB_STEP) - CNW'(tph_q);
				nph  = '0;
			end
			tcw_pkg::CH_CR: begin
				ncol = '0;
				nph  = '0;
			end
			tcw_pkg::CH_LF: begin
				ncol   = '0;
				nph    = '0;
				rowinc = 1'b1;
			end
			default: begin
				if (ctl.code >= tcw_pkg::CH_SPACE) begin
					printable = 1'b1;
					ncol      = CNW'(col_q) + CNW'(1);
					nph       = (tph_q == TPW'(TAB_STEP - 1)) ? '0 : tph_q + TPW'(1);
				end
			end
		endcase
		// column wrap
		if (ncol >= CNW'(COLUMNS)) begin
			ncol   = '0;
			nph    = '0;
			rowinc = 1'b1;
		end
		nrow   = RNW'(row_q) + RNW'(rowinc);
		scroll = (nrow >= RNW'(ROWS));
	end

	assign sts.printable = ctl.put & printable;
	assign sts.scroll    = ctl.put & scroll;

	// cursor registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			tph_q <= '0;
		end else if (ctl.home) begin
			col_q <= '0;
			row_q <= '0;
			tph_q <= '0;
		end else if (ctl.put) begin
			col_q <= CW'(ncol);
			tph_q <= nph;
			row_q <= scroll ? RW'(ROWS - 1) : RW'(nrow);
		end
	end

	// linear position
	assign cur_lin = LW'(row_q) * LW'(COLUMNS) + LW'(col_q);

endmodule
`default_nettype wire

@@ tb/sv/tcw_checker.sv @@
// ----------------------------------------------------------------------------
// tcw_checker
// Watches the config, command and result channels of the text console
// character writer. It keeps its own copy of the cell store, cursor and
// attribute, predicts the result of every command transfer and compares each
// result, field by field, against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tcw_checker #(
	parameter int COLUMNS  = 80,
	parameter int ROWS     = 25,
	parameter int TAB_STEP = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_valid,
	input  wire         cfg_ready,
	input  wire  [7:0]  cfg_data,
	input  wire         start,
	input  wire         busy,
	input  wire  [1:0]  cmd,
	input  wire  [7:0]  char_code,
	input  wire  [10:0] cell_index,
	input  wire         done,
	input  wire  [10:0] cursor_position,
	input  wire  [15:0] read_data,
	output int          fail_count,
	output int          pending_count,
	output int          checked_count,
	output int          scroll_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import tcw_pkg::*;

	localparam int CELL_COUNT   = COLUMNS * ROWS;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [10:0] cursor_position;
		logic [15:0] read_data;
	} console_result_t;

	// shadow of the console state
	logic [15:0]     screen [CELL_COUNT];
	int unsigned     cur_col;
	int unsigned     cur_row;
	logic [7:0]      attribute;
	console_result_t result_q [$];

	function automatic void fill_screen(logic [15:0] value);
		for (int i = 0; i < CELL_COUNT; i++) begin
			screen[i] = value;
		end
	endfunction

	// advance the shadow state by one command and return what it must produce
	function automatic console_result_t apply_command(logic [1:0] op, logic [7:0] code,
			logic [10:0] idx);
		console_result_t r;
		r.read_data = '0;
		case (op)
			CMD_PUT: begin
				if (code == CH_BS) begin
					if (cur_col != 0) begin
						cur_col--;
					end
				end else if (code == CH_TAB) begin
					cur_col = (cur_col / TAB_STEP + 1) * TAB_STEP;
				end else if (code == CH_CR) begin
					cur_col = 0;
				end else if (code == CH_LF) begin
					cur_col = 0;
					cur_row++;
				end else if (code >= CH_SPACE) begin
					screen[cur_row * COLUMNS + cur_col] = {attribute, code};
					cur_col++;
				end
				// column wrap
				if (cur_col >= COLUMNS) begin
					cur_col = 0;
					cur_row++;
				end
				// ran off the bottom: shift lines up, blank the last one
				if (cur_row >= ROWS) begin
					for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
						screen[i] = screen[i + COLUMNS];
					end
					for (int i = (ROWS - 1) * COLUMNS; i < CELL_COUNT; i++) begin
						screen[i] = {attribute, CH_SPACE};
					end
					cur_row = ROWS - 1;
					scroll_count++;
				end
			end
			CMD_CLEAR: begin
				fill_screen({attribute, CH_SPACE});
				cur_col = 0;
				cur_row = 0;
			end
			CMD_READ: begin
				if (idx < CELL_COUNT) begin
					r.read_data = screen[idx];
				end
			end
			default: begin
				// unused command: no effect
			end
		endcase
		r.cursor_position = 11'(cur_row * COLUMNS + cur_col);
		return r;
	endfunction

	task automatic report(string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT) begin
			$display("%0t ns: %s", $time, msg);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		console_result_t want;
		if (!arst_n) begin
			fill_screen({ATTR_RESET, CH_SPACE});
			cur_col = 0;
			cur_row = 0;
			attribute = ATTR_RESET;
			result_q.delete();
			fail_count = 0;
			pending_count = 0;
			checked_count = 0;
			scroll_count = 0;
		end else begin
			// results first: a result never belongs to a command taken at this edge
			if (done) begin
				if (result_q.size() == 0) begin
					report($sformatf("result with nothing pending: cursor 0x%0h data 0x%0h",
						cursor_position, read_data));
				end else begin
					want = result_q.pop_front();
					checked_count++;
					if (cursor_position !== want.cursor_position) begin
						report($sformatf("cursor_position expected 0x%0h, got 0x%0h",
							want.cursor_position, cursor_position));
					end
					if (read_data !== want.read_data) begin
						report($sformatf("read_data expected 0x%0h, got 0x%0h",
							want.read_data, read_data));
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				attribute = cfg_data;
			end
			if (start && !busy) begin
				result_q.push_back(apply_command(cmd, char_code, cell_index));
			end
			pending_count = result_q.size();
		end
	end

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench for the text console character writer. Drives a short directed
// sequence of control bytes, printable bytes, reads and clears, then bursty
// random command traffic under several attribute settings; the checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tcw_pkg::*;

	localparam int         COLUMNS     = 80;
	localparam int         ROWS        = 25;
	localparam int         TAB_STEP    = 8;
	localparam int         PHASES      = 5;
	localparam int         PHASE_ITEMS = 185;
	localparam int         STALL_LIMIT = 20000;
	localparam int         TAIL_CYCLES = 16;
	localparam logic [1:0] CMD_UNUSED  = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;
	logic        start;
	logic        busy;
	logic [1:0]  cmd;
	logic [7:0]  char_code;
	logic [10:0] cell_index;
	logic        done;
	logic [10:0] cursor_position;
	logic [15:0] read_data;

	int fail_count;
	int pending_count;
	int checked_count;
	int scroll_count;

	int unsigned burst_left = 0;
	int unsigned quiet_cycles = 0;
	int unsigned put_count = 0;
	int unsigned read_count = 0;
	int unsigned clear_count = 0;
	int unsigned unused_count = 0;
	int unsigned attr_writes = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	text_console_character_writer #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS),
		.TAB_STEP(TAB_STEP)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.start          (start),
		.busy           (busy),
		.cmd            (cmd),
		.char_code      (char_code),
		.cell_index     (cell_index),
		.done           (done),
		.cursor_position(cursor_position),
		.read_data      (read_data)
	);

	tcw_checker #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS),
		.TAB_STEP(TAB_STEP)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.start          (start),
		.busy           (busy),
		.cmd            (cmd),
		.char_code      (char_code),
		.cell_index     (cell_index),
		.done           (done),
		.cursor_position(cursor_position),
		.read_data      (read_data),
		.fail_count     (fail_count),
		.pending_count  (pending_count),
		.checked_count  (checked_count),
		.scroll_count   (scroll_count)
	);

	// watchdog: cycles without any transfer on any channel
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == STALL_LIMIT) begin
			$display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
				STALL_LIMIT, pending_count);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// one command transfer, then maybe a gap before the next burst
	task automatic send_cmd(logic [1:0] c, logic [7:0] code, logic [10:0] idx);
		int unsigned gap;
		@(negedge clk);
		start <= 1'b1;
		cmd <= c;
		char_code <= code;
		cell_index <= idx;
		@(posedge clk);
		while (busy) @(posedge clk);
		case (c)
			CMD_PUT:   put_count++;
			CMD_READ:  read_count++;
			CMD_CLEAR: clear_count++;
			default:   unused_count++;
		endcase
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				@(negedge clk);
				start <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	// drop start and wait for every result and any store walk to finish
	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_count != 0 || busy) @(negedge clk);
	endtask

	task automatic write_attribute(logic [7:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		attr_writes++;
	endtask

	// mostly printable bytes; line feeds often enough to keep scrolling
	function automatic logic [7:0] pick_put_byte();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 58) return 8'($urandom_range(8'h20, 8'hFF));
		if (r < 72) return CH_LF;
		if (r < 80) return CH_TAB;
		if (r < 86) return CH_BS;
		if (r < 90) return CH_CR;
		return 8'($urandom_range(0, 8'h1F));
	endfunction

	// bias reads toward the rows where writing happens
	function automatic logic [10:0] pick_read_index();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45) return 11'($urandom_range(0, 2047));
		if (r < 85) return 11'((ROWS - 1) * COLUMNS + $urandom_range(0, COLUMNS - 1));
		return 11'($urandom_range(0, 2 * COLUMNS - 1));
	endfunction

	initial begin : stimulus
		logic [7:0]  attr_plan [PHASES];
		int unsigned r;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		start = 1'b0;
		cmd = CMD_PUT;
		char_code = '0;
		cell_index = '0;
		attr_plan[0] = 8'h00;
		attr_plan[1] = 8'hFF;
		attr_plan[2] = 8'($urandom);
		attr_plan[3] = 8'h80;
		attr_plan[4] = 8'($urandom);
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// directed: reset content, ignored controls, printable extremes,
		// backspace at the left edge, tabs up to the column wrap, CR/LF,
		// reads at and past the end of the store, unused command, clear
		send_cmd(CMD_READ, 8'h00, 11'd0);
		send_cmd(CMD_PUT, CH_BS, 11'd0);
		send_cmd(CMD_PUT, 8'h00, 11'd0);
		send_cmd(CMD_PUT, 8'h1F, 11'd0);
		send_cmd(CMD_PUT, CH_SPACE, 11'd0);
		send_cmd(CMD_PUT, 8'h7F, 11'd0);
		send_cmd(CMD_PUT, 8'hFF, 11'd0);
		send_cmd(CMD_PUT, 8'h41, 11'd0);
		send_cmd(CMD_PUT, CH_BS, 11'd0);
		send_cmd(CMD_READ, 8'h00, 11'd2);
		for (int i = 0; i < COLUMNS / TAB_STEP; i++) begin
			send_cmd(CMD_PUT, CH_TAB, 11'd0);
		end
		send_cmd(CMD_PUT, CH_CR, 11'd0);
		send_cmd(CMD_PUT, CH_LF, 11'd0);
		send_cmd(CMD_READ, 8'h00, 11'd1999);
		send_cmd(CMD_READ, 8'h00, 11'd2000);
		send_cmd(CMD_READ, 8'hFF, 11'd2047);
		send_cmd(CMD_UNUSED, 8'hFF, 11'd2047);
		send_cmd(CMD_CLEAR, 8'h00, 11'd0);

		// random traffic, one attribute setting per phase
		for (int p = 0; p < PHASES; p++) begin
			write_attribute(attr_plan[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(0, 999);
				if (r < 4) begin
					send_cmd(CMD_CLEAR, 8'($urandom), 11'($urandom));
				end else if (r < 40) begin
					send_cmd(CMD_UNUSED, 8'($urandom), 11'($urandom));
				end else if (r < 190) begin
					send_cmd(CMD_READ, 8'($urandom), pick_read_index());
				end else begin
					send_cmd(CMD_PUT, pick_put_byte(), 11'($urandom));
				end
			end
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Covered %0d commands: %0d put, %0d read, %0d clear, %0d unused",
			put_count + read_count + clear_count + unused_count,
			put_count, read_count, clear_count, unused_count);
		$display("%0d attribute writes, %0d results checked, %0d scrolls",
			attr_writes, checked_count, scroll_count);
		if (fail_count == 0 && pending_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d results never arrived", fail_count, pending_count);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_cursor.sv
hw/rtl/text_console_character_writer.sv
tb/sv/tcw_checker.sv
tb/sv/tb.sv
